[design/sled_pkg.sv]
// Shared types, constants and helpers for the status LED pattern generator.
`default_nettype none
package sled_pkg;

	localparam int NUM_TIMERS     = 5;
	localparam int NUM_FLAGS      = 6;
	localparam int PERIOD_W       = 16;
	localparam int LED_W          = 8;
	localparam int OP_W           = 3;
	localparam int CFG_IDX_W      = 3;
	localparam int PHASE_BITS_DEF = 16;

	// timer slots
	localparam int T_POWER = 0;
	localparam int T_BLE   = 1;
	localparam int T_WIFI  = 2;
	localparam int T_ERR   = 3;
	localparam int T_SLEEP = 4;

	// status flag bits, in opcode order (flag = opcode - 1)
	localparam int FL_POWER = 0;
	localparam int FL_BLE   = 1;
	localparam int FL_WIFI  = 2;
	localparam int FL_ERR   = 3;
	localparam int FL_SEND  = 4;
	localparam int FL_SLEEP = 5;

	typedef enum logic [OP_W-1:0] {
		OP_TICK,
		OP_POWER,
		OP_BLE,
		OP_WIFI,
		OP_ERR,
		OP_SEND,
		OP_SLEEP,
		OP_BUTTON
	} opcode_t;

	typedef logic [PERIOD_W-1:0] period_t;
	typedef logic [LED_W-1:0]    level_t;

	localparam period_t PERIOD_RESET [NUM_TIMERS] = '{
		period_t'(200), period_t'(100), period_t'(100), period_t'(50), period_t'(100)
	};

	// phase points of the blink patterns
	localparam int PH_ZERO     = 0;
	localparam int PH_ONE      = 1;
	localparam int BLE_OFF_PH  = 11;
	localparam int WIFI_ON_A   = 21;
	localparam int WIFI_OFF_A  = 31;
	localparam int WIFI_ON_B   = 41;
	localparam int WIFI_OFF_B  = 51;

	// LED levels
	localparam level_t LVL_BRIGHT = 8'h33;
	localparam level_t LVL_DIM    = 8'h11;
	localparam level_t MONO_BLINK = 8'h01;
	localparam level_t MONO_OFF   = 8'hff;

	// button character codes
	localparam level_t BTN_A = 8'h41;
	localparam level_t BTN_B = 8'h42;
	localparam level_t BTN_X = 8'h58;
	localparam level_t BTN_Y = 8'h59;

	typedef struct packed {
		logic busy;
		logic done;
	} pass_stat_t;

	typedef struct packed {
		level_t red;
		level_t green;
		level_t blue;
		level_t mono;
	} led_result_t;

	// a period of zero behaves as a period of one
	function automatic period_t eff_period(input period_t p);
		return (p == '0) ? period_t'(1) : p;
	endfunction

endpackage
`default_nettype wire

[design/sled_reduce.sv]
// Bit-serial remainder pass that brings every phase below its period after a config write.
`default_nettype none
module sled_reduce #(
	parameter int PHASE_BITS = sled_pkg::PHASE_BITS_DEF
) (
	input  wire logic                                                     clk,
	input  wire logic                                                     arst_n,
	input  wire logic                                                     start,
	input  wire logic [sled_pkg::NUM_TIMERS-1:0][sled_pkg::PERIOD_W-1:0]  periods,
	input  wire logic [sled_pkg::NUM_TIMERS-1:0][PHASE_BITS-1:0]          phases_in,
	output sled_pkg::pass_stat_t                                          stat,
	output logic      [sled_pkg::NUM_TIMERS-1:0][PHASE_BITS-1:0]          phases_out
);
	import sled_pkg::*;

	localparam int CNT_W = $clog2(PHASE_BITS + 1);

	logic [CNT_W-1:0]                         cnt_q;
	logic                                     busy_q;
	logic                                     done_q;
	logic [NUM_TIMERS-1:0][PHASE_BITS-1:0]    shift_q;
	logic [NUM_TIMERS-1:0][PERIOD_W-1:0]      rem_q;
	logic [NUM_TIMERS-1:0][PERIOD_W-1:0]      rem_d;

	// one restoring step per lane: shift in the next dividend bit, subtract if it fits
	always_comb begin
		logic [PERIOD_W:0] trial;
		logic [PERIOD_W:0] div;
		for (int t = 0; t < NUM_TIMERS; t++) begin
			trial = {rem_q[t], shift_q[t][PHASE_BITS-1]};
			div   = {1'b0, eff_period(periods[t])};
			if (trial >= div) begin
				trial = trial - div;
			end
			rem_d[t] = trial[PERIOD_W-1:0];
		end
	end

	// sequencer: PHASE_BITS steps, then a one-cycle done strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			shift_q <= '0;
			rem_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				cnt_q   <= CNT_W'(PHASE_BITS);
				shift_q <= phases_in;
				rem_q   <= '0;
			end else if (busy_q) begin
				rem_q <= rem_d;
				for (int t = 0; t < NUM_TIMERS; t++) begin
					shift_q[t] <= {shift_q[t][PHASE_BITS-2:0], 1'b0};
				end
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder never exceeds the dividend, so the resize keeps its value
	always_comb begin
		for (int t = 0; t < NUM_TIMERS; t++) begin
			phases_out[t] = PHASE_BITS'(rem_q[t]);
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;

	a_done_ends_pass: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(busy_q) && !busy_q))
		else $error("remainder pass done without a running pass");

endmodule
`default_nettype wire

[design/sled_state.sv]
// Status flags, phase counters, blink levels and LED level decode for one event.
`default_nettype none
module sled_state #(
	parameter int PHASE_BITS = sled_pkg::PHASE_BITS_DEF
) (
	input  wire logic                                                     clk,
	input  wire logic                                                     arst_n,
	input  wire logic                                                     upd,
	input  wire logic [sled_pkg::OP_W-1:0]                                opcode,
	input  wire logic [sled_pkg::LED_W-1:0]                               event_value,
	input  wire logic [sled_pkg::NUM_TIMERS-1:0][sled_pkg::PERIOD_W-1:0]  periods,
	input  wire sled_pkg::pass_stat_t                                     pass_stat,
	input  wire logic [sled_pkg::NUM_TIMERS-1:0][PHASE_BITS-1:0]          pass_phases,
	output logic      [sled_pkg::NUM_TIMERS-1:0][PHASE_BITS-1:0]          phases,
	output logic                                                          emit,
	output sled_pkg::led_result_t                                         result
);
	import sled_pkg::*;

	localparam int NW = ((PHASE_BITS > PERIOD_W) ? PHASE_BITS : PERIOD_W) + 1;

	logic [NUM_FLAGS-1:0]                  flags_q,  flags_d;
	level_t                                button_q, button_d;
	logic                                  dirty_q,  dirty_d;
	logic [NUM_TIMERS-1:0][PHASE_BITS-1:0] phase_q,  phase_d;
	logic [NUM_TIMERS-1:0][PHASE_BITS-1:0] resid_q,  resid_d;
	logic [NUM_TIMERS-1:0]                 blink_q,  blink_d;
	logic [NUM_TIMERS-1:0][NW-1:0]         nxt;
	opcode_t                               op;

	// phase_q keeps the raw phase, resid_q the same phase reduced below the current period
	assign op     = opcode_t'(opcode);
	assign phases = phase_q;

	// next phase of each timer, taken from the residue
	always_comb begin
		logic [NW-1:0] sp1;
		for (int t = 0; t < NUM_TIMERS; t++) begin
			sp1    = NW'(resid_q[t]) + NW'(1);
			nxt[t] = (sp1 == NW'(eff_period(periods[t]))) ? '0 : sp1;
		end
	end

	// event decode and state update
	always_comb begin
		logic [NUM_TIMERS-1:0] clr;
		logic [2:0]            fidx;
		logic                  flag_v;
		level_t                c;
		flags_d  = flags_q;
		button_d = button_q;
		dirty_d  = dirty_q;
		phase_d  = phase_q;
		resid_d  = resid_q;
		blink_d  = blink_q;
		clr      = '0;
		fidx     = opcode - 3'd1;
		flag_v   = |event_value;
		c        = '0;
		emit     = 1'b0;
		result   = '0;
		case (op)
			OP_TICK: begin
				if (flags_d[FL_POWER]) begin
					phase_d[T_POWER] = PHASE_BITS'(nxt[T_POWER]);
					resid_d[T_POWER] = PHASE_BITS'(nxt[T_POWER]);
					if (nxt[T_POWER] == NW'(PH_ONE)) begin
						blink_d[T_POWER] = 1'b1;
						dirty_d          = 1'b1;
					end else if (nxt[T_POWER] == NW'(PH_ZERO)) begin
						blink_d[T_POWER]  = 1'b0;
						flags_d[FL_POWER] = 1'b0;
						dirty_d           = 1'b1;
					end
				end
				if (flags_d[FL_BLE]) begin
					phase_d[T_BLE] = PHASE_BITS'(nxt[T_BLE]);
					resid_d[T_BLE] = PHASE_BITS'(nxt[T_BLE]);
					if (nxt[T_BLE] == NW'(PH_ONE)) begin
						blink_d[T_BLE] = 1'b1;
						dirty_d        = 1'b1;
					end else if (nxt[T_BLE] == NW'(BLE_OFF_PH)) begin
						blink_d[T_BLE] = 1'b0;
						dirty_d        = 1'b1;
					end
				end
				if (flags_d[FL_WIFI]) begin
					phase_d[T_WIFI] = PHASE_BITS'(nxt[T_WIFI]);
					resid_d[T_WIFI] = PHASE_BITS'(nxt[T_WIFI]);
					if (nxt[T_WIFI] == NW'(WIFI_ON_A) || nxt[T_WIFI] == NW'(WIFI_ON_B)) begin
						blink_d[T_WIFI] = 1'b1;
						dirty_d         = 1'b1;
					end else if (nxt[T_WIFI] == NW'(WIFI_OFF_A)
							|| nxt[T_WIFI] == NW'(WIFI_OFF_B)) begin
						blink_d[T_WIFI] = 1'b0;
						dirty_d         = 1'b1;
					end
				end
				if (flags_d[FL_ERR]) begin
					phase_d[T_ERR] = PHASE_BITS'(nxt[T_ERR]);
					resid_d[T_ERR] = PHASE_BITS'(nxt[T_ERR]);
					if (nxt[T_ERR] == NW'(PH_ZERO)) begin
						blink_d[T_ERR] = !blink_d[T_ERR];
						dirty_d        = 1'b1;
					end
				end
				if (flags_d[FL_SLEEP]) begin
					phase_d[T_SLEEP] = PHASE_BITS'(nxt[T_SLEEP]);
					resid_d[T_SLEEP] = PHASE_BITS'(nxt[T_SLEEP]);
					if (nxt[T_SLEEP] == NW'(PH_ZERO)) begin
						blink_d[T_SLEEP] = !blink_d[T_SLEEP];
						dirty_d          = 1'b1;
					end
				end

				emit    = dirty_d;
				dirty_d = 1'b0;

				// RGB by priority
				if (blink_d[T_POWER]) begin
					result.red   = LVL_BRIGHT;
					result.green = LVL_BRIGHT;
					result.blue  = LVL_BRIGHT;
				end else if (blink_d[T_BLE] || blink_d[T_WIFI]) begin
					result.green = LVL_DIM;
					result.blue  = LVL_DIM;
				end else begin
					case (button_d)
						BTN_A: result.green = LVL_DIM;
						BTN_B: result.red   = LVL_DIM;
						BTN_X: result.blue  = LVL_DIM;
						BTN_Y: begin
							result.red   = LVL_DIM;
							result.green = LVL_DIM;
						end
						default: ;
					endcase
				end

				// single LED: lit when the level code lands in 1..16
				if (blink_d[T_POWER]) begin
					c = LVL_DIM;
				end else if (blink_d[T_BLE] || blink_d[T_WIFI] || blink_d[T_ERR]) begin
					c = MONO_BLINK;
				end
				if (flags_d[FL_SEND]) begin
					c = c + level_t'(1);
				end else if (flags_d[FL_SLEEP]) begin
					c = level_t'(blink_d[T_SLEEP]);
				end
				result.mono = (c != '0 && c < LVL_DIM) ? '0 : MONO_OFF;
			end
			OP_BUTTON: begin
				if (button_d != event_value) begin
					button_d = event_value;
					dirty_d  = 1'b1;
				end
			end
			default: begin
				// timers that a status change restarts
				case (op)
					OP_POWER: clr[T_POWER] = 1'b1;
					OP_BLE, OP_WIFI: begin
						clr[T_BLE]  = 1'b1;
						clr[T_WIFI] = 1'b1;
					end
					OP_ERR:   clr[T_SLEEP] = 1'b1;
					OP_SEND: begin
						clr[T_ERR]   = 1'b1;
						clr[T_SLEEP] = 1'b1;
					end
					OP_SLEEP: begin
						clr[T_ERR]  = 1'b1;
						clr[T_BLE]  = 1'b1;
						clr[T_WIFI] = 1'b1;
					end
					default: clr = '0;
				endcase
				if (flags_d[fidx] != flag_v) begin
					for (int t = 0; t < NUM_TIMERS; t++) begin
						if (clr[t]) begin
							phase_d[t] = '0;
							resid_d[t] = '0;
							blink_d[t] = 1'b0;
						end
					end
					flags_d[fidx] = flag_v;
					dirty_d       = 1'b1;
				end
			end
		endcase
	end

	// state registers; the remainder pass writes residues only when no event updates the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q  <= NUM_FLAGS'(1) << FL_POWER;
			button_q <= '0;
			dirty_q  <= 1'b1;
			phase_q  <= '0;
			resid_q  <= '0;
			blink_q  <= '0;
		end else if (upd) begin
			flags_q  <= flags_d;
			button_q <= button_d;
			dirty_q  <= dirty_d;
			phase_q  <= phase_d;
			resid_q  <= resid_d;
			blink_q  <= blink_d;
		end else if (pass_stat.done) begin
			resid_q <= pass_phases;
		end
	end

	a_power_blink_needs_flag: assert property (@(posedge clk) disable iff (!arst_n)
		blink_q[T_POWER] |-> flags_q[FL_POWER])
		else $error("power blink lit with power status off");

	a_emit_clears_dirty: assert property (@(posedge clk) disable iff (!arst_n)
		(upd && emit) |=> !dirty_q)
		else $error("dirty mark survived an emitted beat");

endmodule
`default_nettype wire

[design/status_led_pattern_generator.sv]
// Top level of the status LED pattern generator: handshakes, config registers, stages.
//
// Input channel (in_valid/in_ready): one beat is one event, opcode plus event_value.
// A tick advances the blink timers; any other opcode updates one status or the
// button code and never produces an output beat.
// Output channel (out_valid/out_ready): one beat of red, green, blue and mono_level,
// produced by a tick that finds the display changed since the last output beat.
// An accepted tick is registered in the input register and decoded from there; its
// output beat is loaded into the output register when the input stage advances.
// Throughput: one event per cycle while in_ready is high; a stalled output register
// holds its beat, and the input register moves unless it carries a tick that must emit.
// Config port (cfg_we/cfg_index/cfg_data): writes one period register at once.
// Each write starts a bit-serial remainder pass over the five phase counters;
// in_ready is low in the write cycle and while the pass runs.
// Reset: periods return to their defaults, power status on, all timers at zero,
// display marked changed so the first tick emits.
`default_nettype none
module status_led_pattern_generator #(
	parameter int PHASE_BITS = sled_pkg::PHASE_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [sled_pkg::OP_W-1:0]           opcode,
	input  wire logic [sled_pkg::LED_W-1:0]          event_value,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic      [sled_pkg::LED_W-1:0]          red,
	output logic      [sled_pkg::LED_W-1:0]          green,
	output logic      [sled_pkg::LED_W-1:0]          blue,
	output logic      [sled_pkg::LED_W-1:0]          mono_level,
	input  wire logic                                cfg_we,
	input  wire logic [sled_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [sled_pkg::PERIOD_W-1:0]       cfg_data
);
	import sled_pkg::*;

	logic [NUM_TIMERS-1:0][PERIOD_W-1:0]   periods_q;
	logic [NUM_TIMERS-1:0][PHASE_BITS-1:0] phases;
	logic [NUM_TIMERS-1:0][PHASE_BITS-1:0] pass_phases;
	pass_stat_t                            pstat;

	logic                s1_valid;
	logic [OP_W-1:0]     op_s1;
	level_t              val_s1;
	logic                s1_adv;
	logic                emit;
	led_result_t         res;

	logic                out_valid_q;
	led_result_t         res_q;

	// period registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < NUM_TIMERS; t++) begin
				periods_q[t] <= PERIOD_RESET[t];
			end
		end else if (cfg_we && cfg_index < CFG_IDX_W'(NUM_TIMERS)) begin
			periods_q[cfg_index] <= cfg_data;
		end
	end

	// input stage moves on unless it holds an emitting tick behind a full output
	assign s1_adv   = s1_valid && (!emit || !out_valid_q || out_ready);
	assign in_ready = !pstat.busy && !cfg_we && (!s1_valid || s1_adv);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (in_valid && in_ready) begin
			s1_valid <= 1'b1;
		end else if (s1_adv) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1  <= opcode;
			val_s1 <= event_value;
		end
	end

	sled_state #(
		.PHASE_BITS (PHASE_BITS)
	) u_state (
		.clk         (clk),
		.arst_n      (arst_n),
		.upd         (s1_adv),
		.opcode      (op_s1),
		.event_value (val_s1),
		.periods     (periods_q),
		.pass_stat   (pstat),
		.pass_phases (pass_phases),
		.phases      (phases),
		.emit        (emit),
		.result      (res)
	);

	sled_reduce #(
		.PHASE_BITS (PHASE_BITS)
	) u_reduce (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (cfg_we),
		.periods    (periods_q),
		.phases_in  (phases),
		.stat       (pstat),
		.phases_out (pass_phases)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && emit) begin
			res_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign red        = res_q.red;
	assign green      = res_q.green;
	assign blue       = res_q.blue;
	assign mono_level = res_q.mono;

	a_no_accept_in_pass: assert property (@(posedge clk) disable iff (!arst_n)
		pstat.busy |-> !(in_valid && in_ready))
		else $error("event accepted during the remainder pass");

	a_stalled_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid && !s1_adv) |=> (s1_valid && $stable(op_s1) && $stable(val_s1)))
		else $error("stalled event lost from the input stage");

endmodule
`default_nettype wire

[tb/sv/status_led_pattern_generator_tb.sv]
// Self-checking testbench for the status LED pattern generator: random events, own predictor.
`default_nettype none
module status_led_pattern_generator_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sled_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 4;
	localparam int NUM_PHASES     = 7;
	localparam int PHASE_ITEMS    = 250;
	localparam int MAX_SHOWN      = 40;

	typedef struct {
		opcode_t     op;
		logic [7:0]  val;
	} led_event_t;

	// DUT signals
	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [OP_W-1:0]      opcode = '0;
	logic [LED_W-1:0]     event_value = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [LED_W-1:0]     red, green, blue, mono_level;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [PERIOD_W-1:0]  cfg_data = '0;

	// stimulus and scoreboard
	led_event_t  event_q[$];
	led_result_t led_expect_q[$];
	int          items_queued = 0;
	int          items_taken = 0;
	int          beats_checked = 0;
	int          cfg_writes = 0;
	int          mismatches = 0;
	int          idle_cycles = 0;
	int          send_idle_pct = 0;
	int          stall_pct = 0;
	bit          in_beat_taken = 1'b0;

	// predictor state
	period_t              period_reg [NUM_TIMERS];
	period_t              phase_now  [NUM_TIMERS];
	logic                 blink_on   [NUM_TIMERS];
	logic [NUM_FLAGS-1:0] status_bits;
	logic [7:0]           button_char;
	logic                 display_dirty;

	status_led_pattern_generator uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .event_value(event_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.red(red), .green(green), .blue(blue), .mono_level(mono_level),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		if (mismatches <= MAX_SHOWN) begin
			$display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
		end
	endtask

	// ---------------- predictor ----------------
	function automatic void clear_blink(input int t);
		phase_now[t] = '0;
		blink_on[t] = 1'b0;
	endfunction

	// next phase is (stored + 1) mod period; zero period acts as one
	function automatic int unsigned next_phase(input int t);
		int unsigned span;
		int unsigned nxt;
		span = (period_reg[t] == '0) ? 1 : int'(period_reg[t]);
		nxt = (32'(phase_now[t]) + 1) % span;
		phase_now[t] = period_t'(nxt);
		return nxt;
	endfunction

	function automatic void update_status(input int flag, input logic on);
		if (status_bits[flag] == on) return;
		case (flag)
			FL_POWER: clear_blink(T_POWER);
			FL_BLE, FL_WIFI: begin
				clear_blink(T_BLE);
				clear_blink(T_WIFI);
			end
			FL_ERR: clear_blink(T_SLEEP);
			FL_SEND: begin
				clear_blink(T_ERR);
				clear_blink(T_SLEEP);
			end
			default: begin
				clear_blink(T_ERR);
				clear_blink(T_BLE);
				clear_blink(T_WIFI);
			end
		endcase
		status_bits[flag] = on;
		display_dirty = 1'b1;
	endfunction

	function automatic void advance_timers();
		int unsigned ph;
		if (status_bits[FL_POWER]) begin
			ph = next_phase(T_POWER);
			if (ph == PH_ONE) begin
				blink_on[T_POWER] = 1'b1;
				display_dirty = 1'b1;
			end else if (ph == PH_ZERO) begin
				blink_on[T_POWER] = 1'b0;
				status_bits[FL_POWER] = 1'b0;
				display_dirty = 1'b1;
			end
		end
		if (status_bits[FL_BLE]) begin
			ph = next_phase(T_BLE);
			if (ph == PH_ONE) begin
				blink_on[T_BLE] = 1'b1;
				display_dirty = 1'b1;
			end else if (ph == BLE_OFF_PH) begin
				blink_on[T_BLE] = 1'b0;
				display_dirty = 1'b1;
			end
		end
		if (status_bits[FL_WIFI]) begin
			ph = next_phase(T_WIFI);
			if (ph == WIFI_ON_A || ph == WIFI_ON_B) begin
				blink_on[T_WIFI] = 1'b1;
				display_dirty = 1'b1;
			end else if (ph == WIFI_OFF_A || ph == WIFI_OFF_B) begin
				blink_on[T_WIFI] = 1'b0;
				display_dirty = 1'b1;
			end
		end
		if (status_bits[FL_ERR] && next_phase(T_ERR) == PH_ZERO) begin
			blink_on[T_ERR] = ~blink_on[T_ERR];
			display_dirty = 1'b1;
		end
		if (status_bits[FL_SLEEP] && next_phase(T_SLEEP) == PH_ZERO) begin
			blink_on[T_SLEEP] = ~blink_on[T_SLEEP];
			display_dirty = 1'b1;
		end
	endfunction

	// one accepted event; a tick that leaves the display dirty yields one expected beat
	function automatic void apply_led_event(input opcode_t op, input logic [7:0] val);
		led_result_t want;
		int unsigned lvl;
		case (op)
			OP_POWER: update_status(FL_POWER, val != 0);
			OP_BLE:   update_status(FL_BLE, val != 0);
			OP_WIFI:  update_status(FL_WIFI, val != 0);
			OP_ERR:   update_status(FL_ERR, val != 0);
			OP_SEND:  update_status(FL_SEND, val != 0);
			OP_SLEEP: update_status(FL_SLEEP, val != 0);
			OP_BUTTON: begin
				if (button_char != val) begin
					button_char = val;
					display_dirty = 1'b1;
				end
			end
			default: begin
				advance_timers();
				if (display_dirty) begin
					display_dirty = 1'b0;
					want = '0;
					// RGB by priority
					if (blink_on[T_POWER]) begin
						want.red = LVL_BRIGHT;
						want.green = LVL_BRIGHT;
						want.blue = LVL_BRIGHT;
					end else if (blink_on[T_BLE] || blink_on[T_WIFI]) begin
						want.green = LVL_DIM;
						want.blue = LVL_DIM;
					end else begin
						case (button_char)
							BTN_A: want.green = LVL_DIM;
							BTN_B: want.red = LVL_DIM;
							BTN_X: want.blue = LVL_DIM;
							BTN_Y: begin
								want.red = LVL_DIM;
								want.green = LVL_DIM;
							end
							default: ;
						endcase
					end
					// single LED
					lvl = 0;
					if (blink_on[T_POWER])
						lvl = 32'(LVL_DIM);
					else if (blink_on[T_BLE] || blink_on[T_WIFI] || blink_on[T_ERR])
						lvl = 32'(MONO_BLINK);
					if (status_bits[FL_SEND])
						lvl++;
					else if (status_bits[FL_SLEEP])
						lvl = blink_on[T_SLEEP] ? 1 : 0;
					want.mono = (lvl > 0 && lvl < LVL_DIM) ? '0 : MONO_OFF;
					led_expect_q.push_back(want);
				end
			end
		endcase
	endfunction

	// ---------------- driver ----------------
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_beat_taken)) begin
			if (event_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				opcode <= event_q[0].op;
				event_value <= event_q[0].val;
				void'(event_q.pop_front());
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// ---------------- monitor, checker, watchdog ----------------
	always @(posedge clk) begin : monitor
		led_result_t want;
		bit out_beat;
		in_beat_taken = arst_n && in_valid && in_ready;
		out_beat = arst_n && out_valid && out_ready;
		if (out_beat) begin
			beats_checked++;
			if (led_expect_q.size() == 0) begin
				report_mismatch("output beat with none pending", int'(red), 0);
			end else begin
				want = led_expect_q.pop_front();
				if (red !== want.red)
					report_mismatch("red", int'(red), int'(want.red));
				if (green !== want.green)
					report_mismatch("green", int'(green), int'(want.green));
				if (blue !== want.blue)
					report_mismatch("blue", int'(blue), int'(want.blue));
				if (mono_level !== want.mono)
					report_mismatch("mono_level", int'(mono_level), int'(want.mono));
			end
		end
		if (in_beat_taken) begin
			apply_led_event(opcode_t'(opcode), event_value);
			items_taken++;
		end
		idle_cycles = (in_beat_taken || out_beat) ? 0 : idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no beat for %0d cycles, %0d results outstanding",
				idle_cycles, led_expect_q.size());
			$display("** status_led_pattern_generator: FAILED **");
			$finish;
		end
	end

	// ---------------- sequencing helpers ----------------
	task automatic push_event(input opcode_t op, input logic [7:0] val);
		led_event_t ev;
		ev.op = op;
		ev.val = val;
		event_q.push_back(ev);
		items_queued++;
	endtask

	task automatic wait_drained(input int settle);
		while (items_taken != items_queued || led_expect_q.size() != 0) @(negedge clk);
		repeat (settle) @(negedge clk);
	endtask

	// block must be idle; waits for the remainder pass to finish
	task automatic write_period(input logic [CFG_IDX_W-1:0] idx, input period_t val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx < NUM_TIMERS) period_reg[idx] = val;
		cfg_writes++;
		@(negedge clk);
		while (!in_ready) @(negedge clk);
	endtask

	task automatic write_all(input int p0, p1, p2, p3, p4);
		write_period(CFG_IDX_W'(T_POWER), period_t'(p0));
		write_period(CFG_IDX_W'(T_BLE), period_t'(p1));
		write_period(CFG_IDX_W'(T_WIFI), period_t'(p2));
		write_period(CFG_IDX_W'(T_ERR), period_t'(p3));
		write_period(CFG_IDX_W'(T_SLEEP), period_t'(p4));
	endtask

	// mostly ticks so the blink patterns run, with status and button changes mixed in
	task automatic queue_random(input int n);
		opcode_t op;
		logic [7:0] val;
		repeat (n) begin
			if ($urandom_range(99) < 72) begin
				op = OP_TICK;
				val = 8'($urandom);
			end else begin
				op = opcode_t'($urandom_range(OP_POWER, OP_BUTTON));
				if (op == OP_BUTTON) begin
					case ($urandom_range(5))
						0: val = BTN_A;
						1: val = BTN_B;
						2: val = BTN_X;
						3: val = BTN_Y;
						4: val = 8'h00;
						default: val = 8'($urandom);
					endcase
				end else begin
					val = $urandom_range(1) ? 8'h00 : 8'($urandom_range(1, 255));
				end
			end
			push_event(op, val);
		end
	endtask

	// ---------------- main sequence ----------------
	initial begin : main
		int phase;
		int idx;
		for (int t = 0; t < NUM_TIMERS; t++) begin
			period_reg[t] = PERIOD_RESET[t];
			phase_now[t] = '0;
			blink_on[t] = 1'b0;
		end
		status_bits = '0;
		status_bits[FL_POWER] = 1'b1;
		button_char = '0;
		display_dirty = 1'b1;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every opcode, value extremes, unchanged statuses, all buttons
		push_event(OP_TICK, 8'h00);
		push_event(OP_BUTTON, BTN_A);
		push_event(OP_TICK, 8'hff);
		push_event(OP_BUTTON, BTN_A);
		push_event(OP_TICK, 8'h00);
		push_event(OP_BLE, 8'hff);
		push_event(OP_BLE, 8'h01);
		push_event(OP_TICK, 8'h00);
		push_event(OP_WIFI, 8'h80);
		push_event(OP_ERR, 8'h01);
		push_event(OP_SEND, 8'hff);
		push_event(OP_TICK, 8'h00);
		push_event(OP_SLEEP, 8'h01);
		push_event(OP_SEND, 8'h00);
		push_event(OP_TICK, 8'h00);
		push_event(OP_POWER, 8'h00);
		push_event(OP_TICK, 8'h00);
		push_event(OP_BUTTON, BTN_B);
		push_event(OP_TICK, 8'h00);
		push_event(OP_BUTTON, BTN_X);
		push_event(OP_BUTTON, BTN_Y);
		push_event(OP_TICK, 8'h00);
		push_event(OP_BUTTON, 8'hff);
		push_event(OP_POWER, 8'hff);
		push_event(OP_TICK, 8'h00);

		for (phase = 0; phase < NUM_PHASES; phase++) begin
			wait_drained(SETTLE_CYCLES);
			case (phase)
				0: ; // reset periods
				1: write_all(4, 15, 60, 3, 5);
				2: begin
					write_all(0, 0, 0, 0, 0);
					for (idx = NUM_TIMERS; idx < (1 << CFG_IDX_W); idx++)
						write_period(CFG_IDX_W'(idx), period_t'($urandom));
				end
				3: write_all(16'hffff, 1000, 16'hffff, 300, 700);
				// phases left high by the previous setting are reduced below the new periods here
				4: write_all(7, 13, 53, 2, 9);
				5: write_all($urandom_range(1, 80), $urandom_range(1, 80),
					$urandom_range(52, 110), $urandom_range(1, 80), $urandom_range(1, 80));
				default: write_all(1, 12, 52, 1, 1);
			endcase
			@(posedge clk);
			case (phase)
				1, 5: begin send_idle_pct = 68; stall_pct = 0; end
				2, 6: begin send_idle_pct = 0; stall_pct = 68; end
				3: begin send_idle_pct = 33; stall_pct = 33; end
				default: begin send_idle_pct = 0; stall_pct = 0; end
			endcase
			queue_random(PHASE_ITEMS / 2);
			// sender holds off until every pending result is out
			wait_drained(0);
			@(posedge clk);
			queue_random(PHASE_ITEMS - PHASE_ITEMS / 2);
		end

		wait_drained(2 * SETTLE_CYCLES);
		$display("covered %0d events and %0d LED result beats over %0d period settings",
			items_taken, beats_checked, NUM_PHASES);
		$display("%0d config writes (zero, one, full-scale and unused indexes), %0d mismatches",
			cfg_writes, mismatches);
		if (mismatches == 0) begin
			$display("** status_led_pattern_generator: PASSED **");
		end else begin
			$display("** status_led_pattern_generator: FAILED **");
		end
		$finish;
	end

endmodule
`default_nettype wire
